>>> sv/tari_pkg.sv
// ============================================================================
// tari_pkg
// Shared types and constants for the two-axis setpoint ramp.
// ============================================================================
`default_nettype none

package tari_pkg;

    localparam int TIME_WIDTH_DEF  = 16;
    localparam int FRAME_SHIFT_DEF = 3;

    localparam int ANG_W     = 16;  // Q8.8 angle
    localparam int POS_W     = 24;  // Q8.16 position
    localparam int STEP_W    = 25;  // per-frame step, full range in one frame
    localparam int SUM_W     = 26;  // position plus step before clamping
    localparam int MAG_W     = 24;  // magnitude of the distance to go
    localparam int CNT_W     = 5;   // divider iteration count
    localparam int CFG_IDX_W = 2;
    localparam int RESET_FRAMES = 8;

    localparam logic signed [ANG_W-1:0] TILT_MIN_RST = 16'sd1280;
    localparam logic signed [ANG_W-1:0] TILT_MAX_RST = 16'sd15360;
    localparam logic signed [ANG_W-1:0] PAN_MIN_RST  = -16'sd11520;
    localparam logic signed [ANG_W-1:0] PAN_MAX_RST  = 16'sd11520;

    localparam logic FUNC_CMD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TILT_MIN = 2'd0,
        CFG_TILT_MAX = 2'd1,
        CFG_PAN_MIN  = 2'd2,
        CFG_PAN_MAX  = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_UPD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic div_load;   // latch distance to go into the divider
        logic div_step;   // one restoring-division iteration
        logic upd;        // add step and clamp
        logic use_quot;   // take the fresh quotient as the step
        logic zero_step;  // move finished, clear the step
    } lane_ctrl_t;

    typedef struct packed {
        logic signed [ANG_W-1:0] lo;
        logic signed [ANG_W-1:0] hi;
    } limits_t;

endpackage

`default_nettype wire

>>> sv/tari_if.sv
// ============================================================================
// tari_if
// Valid/ready channels: command/tick input, angle result, register write.
// ============================================================================
`default_nettype none

interface tari_in_if #(
    parameter int TIME_W = tari_pkg::TIME_WIDTH_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                func;
    logic signed [tari_pkg::ANG_W-1:0]   target_tilt;
    logic signed [tari_pkg::ANG_W-1:0]   target_pan;
    logic        [TIME_W-1:0]            move_time;

    modport source (output valid, func, target_tilt, target_pan, move_time, input ready);
    modport sink   (input valid, func, target_tilt, target_pan, move_time, output ready);
endinterface

interface tari_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [tari_pkg::ANG_W-1:0]   tilt_out;
    logic signed [tari_pkg::ANG_W-1:0]   pan_out;
    logic                                move_done;

    modport source (output valid, tilt_out, pan_out, move_done, input ready);
    modport sink   (input valid, tilt_out, pan_out, move_done, output ready);
endinterface

interface tari_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [tari_pkg::CFG_IDX_W-1:0]      index;
    logic [tari_pkg::ANG_W-1:0]          data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/tari_ctrl.sv
// ============================================================================
// tari_ctrl
// Sequencer: command filtering, frame/tick bookkeeping, limit registers and
// lane control.
// ============================================================================
`default_nettype none

module tari_ctrl #(
    parameter int TIME_WIDTH  = tari_pkg::TIME_WIDTH_DEF,
    parameter int FRAME_SHIFT = tari_pkg::FRAME_SHIFT_DEF,
    localparam int FW         = TIME_WIDTH - FRAME_SHIFT
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    tari_in_if.sink                             cmd,
    tari_cfg_if.sink                            cfg,
    input  wire                                 slot_free,
    output tari_pkg::lane_ctrl_t                lane_ctrl,
    output logic signed [tari_pkg::ANG_W-1:0]   goal_tilt,
    output logic signed [tari_pkg::ANG_W-1:0]   goal_pan,
    output tari_pkg::limits_t                   lim_tilt,
    output tari_pkg::limits_t                   lim_pan,
    output logic [FW-1:0]                       divisor,
    output logic                                emit,
    output logic                                done
);

    tari_pkg::state_t                   state_reg, state_next;
    logic [tari_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [tari_pkg::ANG_W-1:0]  goal_tilt_reg, goal_tilt_next;
    logic signed [tari_pkg::ANG_W-1:0]  goal_pan_reg, goal_pan_next;
    logic [TIME_WIDTH-1:0]              prev_time_reg, prev_time_next;
    logic                               prev_valid_reg, prev_valid_next;
    logic [FW-1:0]                      frame_total_reg, frame_total_next;
    logic [FW:0]                        tick_count_reg, tick_count_next;
    logic                               fresh_reg, fresh_next;
    logic                               done_reg, done_next;
    tari_pkg::limits_t                  lim_tilt_reg, lim_pan_reg;

    logic          accept;
    logic          cmd_new;
    logic [FW-1:0] frames_in;
    logic [FW:0]   tick_base;
    logic [FW:0]   tick_inc;
    logic          done_now;

    assign cmd.ready = (state_reg == tari_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = cmd.valid && cmd.ready;

    assign frames_in = cmd.move_time[TIME_WIDTH-1:FRAME_SHIFT];
    assign cmd_new   = !prev_valid_reg || (cmd.target_tilt != goal_tilt_reg)
                       || (cmd.target_pan != goal_pan_reg)
                       || (cmd.move_time != prev_time_reg);

    // tick counter restarts on the first tick of a move and stops past the end
    assign tick_base = fresh_reg ? '0 : tick_count_reg;
    assign tick_inc  = (tick_base <= {1'b0, frame_total_reg}) ? tick_base + 1'b1 : tick_base;
    assign done_now  = tick_inc > {1'b0, frame_total_reg};

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        goal_tilt_next   = goal_tilt_reg;
        goal_pan_next    = goal_pan_reg;
        prev_time_next   = prev_time_reg;
        prev_valid_next  = prev_valid_reg;
        frame_total_next = frame_total_reg;
        tick_count_next  = tick_count_reg;
        fresh_next       = fresh_reg;
        done_next        = done_reg;
        lane_ctrl        = '0;
        emit             = 1'b0;

        unique case (state_reg)
            tari_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.func == tari_pkg::FUNC_CMD)
                    begin
                        if (cmd_new)
                        begin
                            prev_valid_next  = 1'b1;
                            goal_tilt_next   = cmd.target_tilt;
                            goal_pan_next    = cmd.target_pan;
                            prev_time_next   = cmd.move_time;
                            frame_total_next = (frames_in == '0) ? FW'(1) : frames_in;
                            fresh_next       = 1'b1;
                            done_next        = 1'b0;
                        end
                        state_next = tari_pkg::ST_EMIT;
                    end
                    else if (fresh_reg)
                    begin
                        lane_ctrl.div_load = 1'b1;
                        cnt_next           = '0;
                        state_next         = tari_pkg::ST_DIV;
                    end
                    else
                    begin
                        state_next = tari_pkg::ST_UPD;
                    end
                end
            end

            tari_pkg::ST_DIV:
            begin
                lane_ctrl.div_step = 1'b1;
                cnt_next           = cnt_reg + 1'b1;
                if (cnt_reg == tari_pkg::CNT_W'(tari_pkg::MAG_W - 1))
                begin
                    state_next = tari_pkg::ST_UPD;
                end
            end

            tari_pkg::ST_UPD:
            begin
                lane_ctrl.upd       = 1'b1;
                lane_ctrl.use_quot  = fresh_reg;
                lane_ctrl.zero_step = done_now;
                tick_count_next     = tick_inc;
                fresh_next          = 1'b0;
                if (done_now)
                begin
                    done_next = 1'b1;
                end
                state_next = tari_pkg::ST_EMIT;
            end

            tari_pkg::ST_EMIT:
            begin
                emit = slot_free;
                if (slot_free)
                begin
                    state_next = tari_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = tari_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tari_pkg::ST_IDLE;
            cnt_reg         <= '0;
            goal_tilt_reg   <= '0;
            goal_pan_reg    <= '0;
            prev_time_reg   <= '0;
            prev_valid_reg  <= 1'b0;
            frame_total_reg <= FW'(tari_pkg::RESET_FRAMES);
            tick_count_reg  <= '0;
            fresh_reg       <= 1'b1;
            done_reg        <= 1'b1;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            goal_tilt_reg   <= goal_tilt_next;
            goal_pan_reg    <= goal_pan_next;
            prev_time_reg   <= prev_time_next;
            prev_valid_reg  <= prev_valid_next;
            frame_total_reg <= frame_total_next;
            tick_count_reg  <= tick_count_next;
            fresh_reg       <= fresh_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_tilt_reg.lo <= tari_pkg::TILT_MIN_RST;
            lim_tilt_reg.hi <= tari_pkg::TILT_MAX_RST;
            lim_pan_reg.lo  <= tari_pkg::PAN_MIN_RST;
            lim_pan_reg.hi  <= tari_pkg::PAN_MAX_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (tari_pkg::cfg_idx_t'(cfg.index))
                tari_pkg::CFG_TILT_MIN: lim_tilt_reg.lo <= cfg.data;
                tari_pkg::CFG_TILT_MAX: lim_tilt_reg.hi <= cfg.data;
                tari_pkg::CFG_PAN_MIN:  lim_pan_reg.lo  <= cfg.data;
                tari_pkg::CFG_PAN_MAX:  lim_pan_reg.hi  <= cfg.data;
                default: ;
            endcase
        end
    end

    assign goal_tilt = goal_tilt_reg;
    assign goal_pan  = goal_pan_reg;
    assign lim_tilt  = lim_tilt_reg;
    assign lim_pan   = lim_pan_reg;
    assign divisor   = frame_total_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

>>> sv/tari_lane.sv
// ============================================================================
// tari_lane
// One axis: position and step registers, a restoring divider for the step
// and the add-and-clamp update.
// ============================================================================
`default_nettype none

module tari_lane #(
    parameter int FW = tari_pkg::TIME_WIDTH_DEF - tari_pkg::FRAME_SHIFT_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  tari_pkg::lane_ctrl_t                lane_ctrl,
    input  wire signed [tari_pkg::ANG_W-1:0]    goal,
    input  tari_pkg::limits_t                   lim,
    input  wire [FW-1:0]                        divisor,
    output logic signed [tari_pkg::ANG_W-1:0]   pos_q
);

    localparam int POS_W  = tari_pkg::POS_W;
    localparam int STEP_W = tari_pkg::STEP_W;
    localparam int SUM_W  = tari_pkg::SUM_W;
    localparam int MAG_W  = tari_pkg::MAG_W;

    logic signed [POS_W-1:0]  pos_reg, pos_next;
    logic signed [STEP_W-1:0] step_reg, step_next;
    logic [FW-1:0]            rem_reg, rem_next;
    logic [MAG_W-1:0]         dq_reg, dq_next;
    logic                     neg_reg, neg_next;

    logic signed [STEP_W-1:0] diff;
    logic [STEP_W-1:0]        diff_abs;
    logic [FW:0]              shifted;
    logic                     fits;
    logic [FW:0]              reduced;
    logic signed [STEP_W-1:0] quot;
    logic signed [STEP_W-1:0] eff_step;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  hi_ext;
    logic signed [SUM_W-1:0]  lo_ext;
    logic signed [SUM_W-1:0]  clamped;

    // distance to go in Q8.16, always below 2^24 in magnitude
    assign diff     = $signed({goal[tari_pkg::ANG_W-1], goal, 8'h00})
                      - $signed({pos_reg[POS_W-1], pos_reg});
    assign diff_abs = diff[STEP_W-1] ? -diff : diff;

    assign shifted  = {rem_reg, dq_reg[MAG_W-1]};
    assign fits     = shifted >= {1'b0, divisor};
    assign reduced  = fits ? shifted - {1'b0, divisor} : shifted;

    assign quot     = neg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});
    assign eff_step = lane_ctrl.use_quot ? quot : step_reg;

    assign sum      = $signed({{(SUM_W-POS_W){pos_reg[POS_W-1]}}, pos_reg})
                      + $signed({{(SUM_W-STEP_W){eff_step[STEP_W-1]}}, eff_step});
    assign hi_ext   = $signed({{(SUM_W-tari_pkg::ANG_W-8){lim.hi[tari_pkg::ANG_W-1]}},
                               lim.hi, 8'h00});
    assign lo_ext   = $signed({{(SUM_W-tari_pkg::ANG_W-8){lim.lo[tari_pkg::ANG_W-1]}},
                               lim.lo, 8'h00});

    // upper limit first, then lower: inverted limits settle at the lower one
    always_comb
    begin
        clamped = sum;
        if (clamped > hi_ext)
        begin
            clamped = hi_ext;
        end
        if (clamped < lo_ext)
        begin
            clamped = lo_ext;
        end
    end

    always_comb
    begin
        pos_next  = pos_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        neg_next  = neg_reg;
        if (lane_ctrl.div_load)
        begin
            rem_next = '0;
            dq_next  = diff_abs[MAG_W-1:0];
            neg_next = diff[STEP_W-1];
        end
        else if (lane_ctrl.div_step)
        begin
            rem_next = reduced[FW-1:0];
            dq_next  = {dq_reg[MAG_W-2:0], fits};
        end
        if (lane_ctrl.upd)
        begin
            pos_next  = clamped[POS_W-1:0];
            step_next = lane_ctrl.zero_step ? '0 : eff_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            step_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        neg_reg <= neg_next;
    end

    // floor to Q8.8
    assign pos_q = pos_reg[POS_W-1:POS_W-tari_pkg::ANG_W];

endmodule

`default_nettype wire

>>> sv/tari_merge.sv
// ============================================================================
// tari_merge
// Joins both lane positions and the done flag into the result register.
// ============================================================================
`default_nettype none

module tari_merge (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 load,
    input  wire signed [tari_pkg::ANG_W-1:0]    tilt_pos,
    input  wire signed [tari_pkg::ANG_W-1:0]    pan_pos,
    input  wire                                 done,
    output logic                                slot_free,
    tari_out_if.source                          res
);

    logic                              valid_reg, valid_next;
    logic signed [tari_pkg::ANG_W-1:0] tilt_reg;
    logic signed [tari_pkg::ANG_W-1:0] pan_reg;
    logic                              done_reg;

    assign slot_free  = !valid_reg || res.ready;
    assign valid_next = load ? 1'b1 : (res.ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tilt_reg <= tilt_pos;
            pan_reg  <= pan_pos;
            done_reg <= done;
        end
    end

    assign res.valid     = valid_reg;
    assign res.tilt_out  = tilt_reg;
    assign res.pan_out   = pan_reg;
    assign res.move_done = done_reg;

endmodule

`default_nettype wire

>>> sv/two_axis_ramp_interpolator.sv
// ============================================================================
// two_axis_ramp_interpolator
// Two-axis setpoint ramp: per-frame steps toward a commanded target, with
// clamping to programmable limits. One result beat per input beat.
// ============================================================================
//
//   channel | modport | beat carries
//   --------+---------+----------------------------------------------
//   cmd     | sink    | func, target_tilt, target_pan, move_time
//   res     | source  | tilt_out, pan_out, move_done
//   cfg     | sink    | index, data (limit registers, always ready)
//
// A command beat goes from IDLE to EMIT, a tick through UPD to EMIT, and the
// first tick after a new command through DIV, UPD and EMIT: in DIV the two
// lane dividers resolve one quotient bit per cycle over 24 bits.
// cmd takes one beat at a time; a finished result waits in the res register
// while the next beat is taken. rst_n clears control, position and step
// state asynchronously; divider and result payload registers carry no reset.
// ============================================================================
`default_nettype none

module two_axis_ramp_interpolator #(
    parameter int TIME_WIDTH  = tari_pkg::TIME_WIDTH_DEF,
    parameter int FRAME_SHIFT = tari_pkg::FRAME_SHIFT_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    tari_in_if.sink     cmd,
    tari_out_if.source  res,
    tari_cfg_if.sink    cfg
);

    localparam int FW = TIME_WIDTH - FRAME_SHIFT;

    tari_pkg::lane_ctrl_t              lane_ctrl;
    logic signed [tari_pkg::ANG_W-1:0] goal_tilt;
    logic signed [tari_pkg::ANG_W-1:0] goal_pan;
    tari_pkg::limits_t                 lim_tilt;
    tari_pkg::limits_t                 lim_pan;
    logic [FW-1:0]                     divisor;
    logic                              emit;
    logic                              done;
    logic                              slot_free;
    logic signed [tari_pkg::ANG_W-1:0] tilt_pos;
    logic signed [tari_pkg::ANG_W-1:0] pan_pos;

    tari_ctrl #(
        .TIME_WIDTH  (TIME_WIDTH),
        .FRAME_SHIFT (FRAME_SHIFT)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .slot_free (slot_free),
        .lane_ctrl (lane_ctrl),
        .goal_tilt (goal_tilt),
        .goal_pan  (goal_pan),
        .lim_tilt  (lim_tilt),
        .lim_pan   (lim_pan),
        .divisor   (divisor),
        .emit      (emit),
        .done      (done)
    );

    tari_lane #(
        .FW (FW)
    ) u_lane_tilt (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_ctrl (lane_ctrl),
        .goal      (goal_tilt),
        .lim       (lim_tilt),
        .divisor   (divisor),
        .pos_q     (tilt_pos)
    );

    tari_lane #(
        .FW (FW)
    ) u_lane_pan (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_ctrl (lane_ctrl),
        .goal      (goal_pan),
        .lim       (lim_pan),
        .divisor   (divisor),
        .pos_q     (pan_pos)
    );

    tari_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (emit),
        .tilt_pos  (tilt_pos),
        .pan_pos   (pan_pos),
        .done      (done),
        .slot_free (slot_free),
        .res       (res)
    );

endmodule

`default_nettype wire

>>> sv/tari_checker.sv
// ============================================================================
// tari_checker
// Port-level checks on the ramp block's cmd and res channels.
// ============================================================================
`default_nettype none

module tari_checker (
    input wire                           clk,
    input wire                           rst_n,
    input wire                           in_valid,
    input wire                           in_ready,
    input wire                           out_valid,
    input wire                           out_ready,
    input wire [tari_pkg::ANG_W-1:0]     out_tilt,
    input wire [tari_pkg::ANG_W-1:0]     out_pan,
    input wire                           out_done
);

    logic       in_beat;
    logic       out_beat;
    logic [2:0] pending_reg, pending_next;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // beats taken on cmd but not yet delivered on res
    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
        begin
            pending_next = pending_reg + 3'd1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_tilt) && $stable(out_pan)
                                    && $stable(out_done))
        else $error("res beat changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> !in_ready)
        else $error("cmd taken again before the previous beat was processed");

    a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'd2)
        else $error("more than two beats in flight");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 3'd0)
        else $error("res beat without a matching cmd beat");

endmodule

bind two_axis_ramp_interpolator tari_checker u_tari_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_tilt  (res.tilt_out),
    .out_pan   (res.pan_out),
    .out_done  (res.move_done)
);

`default_nettype wire
